FILE: src/pds_pkg.sv
// package for the periodic deadline scheduler
// holds field widths, command and status codes, and the table entry types
package pds_pkg;

  localparam int unsigned TIME_W   = 63;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned PER_W    = 32;
  localparam int unsigned RV_W     = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE   = 2'd0,
    CMD_POLL     = 2'd1,
    CMD_COMPLETE = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NO_RUN  = 2'd2,
    ST_RUNNING = 2'd3
  } status_e;

  // one table entry
  typedef struct packed {
    logic [TIME_W-1:0] dl;
    logic [ID_W-1:0]   id;
    logic [PER_W-1:0]  per;
  } entry_t;

  // broadcast to every cell in a cycle
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t ent;
  } cell_cmd_t;

endpackage

FILE: src/pds_in_if.sv
// input channel of the periodic deadline scheduler
// depends on pds_pkg for field widths
interface pds_in_if;
  logic                          valid;
  logic                          ready;
  logic [pds_pkg::CMD_W-1:0]     cmd;
  logic [pds_pkg::TIME_W-1:0]    now_time;
  logic [pds_pkg::ID_W-1:0]      task_id;
  logic [pds_pkg::PER_W-1:0]     period;
  logic signed [pds_pkg::RV_W-1:0] return_value;

  modport source (output valid, cmd, now_time, task_id, period, return_value, input ready);
  modport sink   (input valid, cmd, now_time, task_id, period, return_value, output ready);
endinterface

FILE: src/pds_out_if.sv
// result channel of the periodic deadline scheduler
// depends on pds_pkg for field widths
interface pds_out_if;
  logic                          valid;
  logic                          ready;
  logic [pds_pkg::STATUS_W-1:0]  status;
  logic                          run_now;
  logic [pds_pkg::ID_W-1:0]      due_task;
  logic                          queue_empty;
  logic [pds_pkg::TIME_W-1:0]    earliest_deadline;

  modport source (output valid, status, run_now, due_task, queue_empty, earliest_deadline,
                  input ready);
  modport sink   (input valid, status, run_now, due_task, queue_empty, earliest_deadline,
                  output ready);
endinterface

FILE: src/pds_cell.sv
// one slot of the sorted deadline chain
// depends on pds_pkg for entry_t and cell_cmd_t
module pds_cell (
  input  logic               clk_i,
  input  pds_pkg::cell_cmd_t cmd_i,
  input  logic               occ_i,
  input  logic               prev_after_i,
  input  pds_pkg::entry_t    prev_ent_i,
  input  pds_pkg::entry_t    next_ent_i,
  output logic               after_o,
  output pds_pkg::entry_t    ent_o
);

  pds_pkg::entry_t ent_q, ent_d;

  // new entry sorts behind this one only on a strictly later deadline
  assign after_o = occ_i && (cmd_i.ent.dl > ent_q.dl);

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.ins && !after_o) begin
      ent_d = prev_after_i ? cmd_i.ent : prev_ent_i;
    end else if (cmd_i.pop) begin
      ent_d = next_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o = ent_q;

endmodule

FILE: src/periodic_deadline_scheduler.sv
// top level of the periodic deadline scheduler
// depends on pds_pkg, pds_in_if, pds_out_if and pds_cell
//
// usage
//   in_i carries one command word: create, poll or complete. out_o returns
//   exactly one result word per command, in command order.
//   the waiting tasks sit in a chain of MAX_TASKS cells kept in ascending
//   deadline order; a pop shifts every cell, an insert those behind it.
// command flow
//   a command runs in two steps: the accept cycle registers the word and
//   forms the saturated deadline sum, the execute cycle updates the cell
//   chain and loads the result register. in_i.ready is low while a
//   command waits for its execute cycle, so no new command is taken.
// stalls
//   the result register holds its word while out_o.ready is low; the next
//   command is still accepted, and its execute cycle waits until the
//   result register is free.
// reset
//   rst_ni clears the entry count, the running task and all handshake
//   state; the cell contents need no reset as only occupied cells are read.
module periodic_deadline_scheduler #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pds_in_if.sink    in_i,
  pds_out_if.source out_o
);

  localparam int unsigned CNT_W = $clog2(MAX_TASKS + 1);

  // accepted command word
  logic                         busy_q;
  pds_pkg::cmd_e                cmd_q;
  logic [pds_pkg::TIME_W-1:0]   now_q;
  logic [pds_pkg::ID_W-1:0]     id_q;
  logic [pds_pkg::PER_W-1:0]    per_q;
  logic                         rv_neg_q;
  logic [pds_pkg::TIME_W-1:0]   ins_dl_q;

  // running task
  logic                         run_valid_q;
  logic [pds_pkg::ID_W-1:0]     run_id_q;
  logic [pds_pkg::TIME_W-1:0]   run_dl_q;
  logic [pds_pkg::PER_W-1:0]    run_per_q;

  logic [CNT_W-1:0]             count_q, count_d;

  // result register
  logic                         out_valid_q;
  pds_pkg::status_e             status_q, status_d;
  logic                         run_now_q, run_now_d;
  logic [pds_pkg::ID_W-1:0]     due_q;

  // cell chain
  pds_pkg::entry_t              cell_ent [MAX_TASKS];
  logic [MAX_TASKS:0]           after;
  logic [MAX_TASKS-1:0]         occ;
  pds_pkg::cell_cmd_t           cell_cmd;

  logic                         in_fire, exec;
  logic                         full, head_due;
  logic                         do_ins, do_pop;

  // deadline sum formed at accept, from the incoming word or the running task
  logic [pds_pkg::TIME_W-1:0]   sum_base;
  logic [pds_pkg::PER_W-1:0]    sum_delta;
  logic [pds_pkg::TIME_W:0]     sum_wide;
  logic [pds_pkg::TIME_W-1:0]   sum_sat;

  assign in_i.ready = !busy_q;
  assign in_fire    = in_i.valid && in_i.ready;
  assign exec       = busy_q && (!out_valid_q || out_o.ready);

  always_comb begin
    if (pds_pkg::cmd_e'(in_i.cmd) == pds_pkg::CMD_CREATE) begin
      sum_base  = in_i.now_time;
      sum_delta = in_i.period;
    end else begin
      sum_base  = run_dl_q;
      // zero return value reuses the period, a positive one is the delay
      sum_delta = (in_i.return_value == '0) ? run_per_q : in_i.return_value;
    end
    sum_wide = {1'b0, sum_base} + {{(pds_pkg::TIME_W + 1 - pds_pkg::PER_W){1'b0}}, sum_delta};
    sum_sat  = sum_wide[pds_pkg::TIME_W] ? pds_pkg::TIME_MAX : sum_wide[pds_pkg::TIME_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_fire) begin
      busy_q <= 1'b1;
    end else if (exec) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q    <= pds_pkg::cmd_e'(in_i.cmd);
      now_q    <= in_i.now_time;
      id_q     <= in_i.task_id;
      per_q    <= in_i.period;
      rv_neg_q <= in_i.return_value[pds_pkg::RV_W-1];
      ins_dl_q <= sum_sat;
    end
  end

  // execute decode
  assign full     = (count_q == CNT_W'(MAX_TASKS));
  assign head_due = (count_q != '0) && (now_q >= cell_ent[0].dl);

  always_comb begin
    do_ins    = 1'b0;
    do_pop    = 1'b0;
    status_d  = pds_pkg::ST_OK;
    run_now_d = 1'b0;
    cell_cmd.ent.dl  = ins_dl_q;
    cell_cmd.ent.id  = id_q;
    cell_cmd.ent.per = per_q;
    unique case (cmd_q)
      pds_pkg::CMD_CREATE: begin
        if (full) status_d = pds_pkg::ST_FULL;
        else      do_ins   = 1'b1;
      end
      pds_pkg::CMD_POLL: begin
        if (run_valid_q) begin
          status_d = pds_pkg::ST_RUNNING;
        end else if (head_due) begin
          do_pop    = 1'b1;
          run_now_d = 1'b1;
        end
      end
      pds_pkg::CMD_COMPLETE: begin
        cell_cmd.ent.id  = run_id_q;
        cell_cmd.ent.per = run_per_q;
        if (!run_valid_q) begin
          status_d = pds_pkg::ST_NO_RUN;
        end else if (!rv_neg_q) begin
          // reinsert, dropped when creates filled the table meanwhile
          if (full) status_d = pds_pkg::ST_FULL;
          else      do_ins   = 1'b1;
        end
      end
      default: ;
    endcase
    cell_cmd.ins = exec && do_ins;
    cell_cmd.pop = exec && do_pop;
  end

  always_comb begin
    count_d = count_q;
    if (cell_cmd.ins)      count_d = count_q + CNT_W'(1);
    else if (cell_cmd.pop) count_d = count_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      run_valid_q <= 1'b0;
      run_id_q    <= '0;
      run_dl_q    <= '0;
      run_per_q   <= '0;
    end else begin
      count_q <= count_d;
      if (cell_cmd.pop) begin
        run_valid_q <= 1'b1;
        run_id_q    <= cell_ent[0].id;
        run_dl_q    <= cell_ent[0].dl;
        run_per_q   <= cell_ent[0].per;
      end else if (exec && (cmd_q == pds_pkg::CMD_COMPLETE)) begin
        run_valid_q <= 1'b0;
      end
    end
  end

  // cell row: slot 0 is the head; the virtual slot ahead of it always
  // lets a new entry pass
  assign after[0] = 1'b1;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    pds_pkg::entry_t nxt;
    pds_pkg::entry_t prv;

    assign occ[k] = (count_q > CNT_W'(k));

    if (k == MAX_TASKS - 1) begin : g_last
      assign nxt = cell_ent[k];
    end else begin : g_mid
      assign nxt = cell_ent[k+1];
    end

    if (k == 0) begin : g_head
      assign prv = cell_cmd.ent;
    end else begin : g_body
      assign prv = cell_ent[k-1];
    end

    pds_cell u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cell_cmd),
      .occ_i        (occ[k]),
      .prev_after_i (after[k]),
      .prev_ent_i   (prv),
      .next_ent_i   (nxt),
      .after_o      (after[k+1]),
      .ent_o        (cell_ent[k])
    );
  end

  // result register; head fields read the chain, which holds still until
  // the next execute cycle, and that only comes once this word is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q  <= status_d;
      run_now_q <= run_now_d;
      due_q     <= run_now_d ? cell_ent[0].id : '0;
    end
  end

  assign out_o.valid             = out_valid_q;
  assign out_o.status            = status_q;
  assign out_o.run_now           = run_now_q;
  assign out_o.due_task          = due_q;
  assign out_o.queue_empty       = (count_q == '0);
  assign out_o.earliest_deadline = (count_q == '0) ? '0 : cell_ent[0].dl;

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_TASKS))
    else $error("entry count above table depth");

  a_head_sorted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CNT_W'(2)) |-> (cell_ent[0].dl <= cell_ent[1].dl))
    else $error("head entries out of deadline order");

  a_pop_runs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_cmd.pop |=> (run_valid_q && out_valid_q && run_now_q))
    else $error("pop did not hand out a running task");

  a_exec_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec |=> (out_valid_q && !busy_q))
    else $error("execute cycle did not load a result");

  a_run_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && run_now_q) |-> (status_q == pds_pkg::ST_OK))
    else $error("run_now with non-ok status");
`endif

endmodule

FILE: dv/periodic_deadline_scheduler_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for periodic_deadline_scheduler
// depends on pds_pkg, pds_in_if, pds_out_if and the scheduler rtl
module periodic_deadline_scheduler_tb;

  localparam int unsigned MAX_TASKS      = 16;
  localparam int          N_RANDOM       = 1620;
  localparam int          HOLD_AT        = 400;   // random word count that starts the long hold
  localparam int          PAUSE_AT       = 900;   // random word count that starts the drain pause
  localparam int          LONG_HOLD      = 400;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          DRAIN_CYCLES   = 8;

  localparam int unsigned TIME_W = pds_pkg::TIME_W;
  localparam int unsigned ID_W   = pds_pkg::ID_W;
  localparam int unsigned PER_W  = pds_pkg::PER_W;
  localparam int unsigned RV_W   = pds_pkg::RV_W;

  localparam logic [TIME_W-1:0] TIME_MAX = pds_pkg::TIME_MAX;

  // one result word as the scheduler reports it
  typedef struct packed {
    pds_pkg::status_e  status;
    logic              run_now;
    logic [ID_W-1:0]   due_task;
    logic              queue_empty;
    logic [TIME_W-1:0] earliest_deadline;
  } sched_result_t;

  // one row of the directed table; fixed rows carry a hand-written result
  typedef struct packed {
    pds_pkg::cmd_e     cmd;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   tid;
    logic [PER_W-1:0]  per;
    logic [RV_W-1:0]   rv;
    logic [4:0]        reps;
    logic              fixed;
    sched_result_t     res;
  } stim_row_t;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_e;

  logic clk;
  logic rst_n;

  pds_in_if  in_if ();
  pds_out_if out_if ();

  periodic_deadline_scheduler #(
    .MAX_TASKS(MAX_TASKS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------------
  // predictor state: the sorted waiting table and the task handed out
  // ---------------------------------------------------------------------
  logic [TIME_W-1:0] sched_dl  [MAX_TASKS];
  logic [ID_W-1:0]   sched_id  [MAX_TASKS];
  logic [PER_W-1:0]  sched_per [MAX_TASKS];
  int                sched_count;
  bit                run_valid;
  logic [ID_W-1:0]   run_id;
  logic [TIME_W-1:0] run_dl;
  logic [PER_W-1:0]  run_per;

  sched_result_t expected_results [$];
  stim_row_t     directed_rows [$];

  // random time base that creates and polls mostly follow
  logic [TIME_W-1:0] cur_time;

  int  errors;
  int  n_words;
  int  n_results;
  int  n_pops;
  int  n_full;
  int  n_sat;
  int  idle_cycles;
  bit  hold_req;
  bit  hold_done;

  // deadline sum, clipped at the largest time
  function automatic logic [TIME_W-1:0] sat_sum(input logic [TIME_W-1:0] base,
                                                input logic [PER_W-1:0] delta);
    logic [TIME_W:0] total;
    total = {1'b0, base} + {{(TIME_W + 1 - PER_W){1'b0}}, delta};
    if (total[TIME_W]) begin
      n_sat++;
      return TIME_MAX;
    end
    return total[TIME_W-1:0];
  endfunction

  // insert ahead of every entry with an equal deadline; ok low when full
  task automatic table_put(input logic [TIME_W-1:0] dl, input logic [ID_W-1:0] id,
                           input logic [PER_W-1:0] per, output bit ok);
    int pos;
    ok = 1'b0;
    if (sched_count >= MAX_TASKS) begin
      n_full++;
      return;
    end
    pos = 0;
    while (pos < sched_count && dl > sched_dl[pos]) pos++;
    for (int k = sched_count; k > pos; k--) begin
      sched_dl[k]  = sched_dl[k-1];
      sched_id[k]  = sched_id[k-1];
      sched_per[k] = sched_per[k-1];
    end
    sched_dl[pos]  = dl;
    sched_id[pos]  = id;
    sched_per[pos] = per;
    sched_count++;
    ok = 1'b1;
  endtask

  // advance the predictor by one command word and form its result word
  task automatic predict_word(input pds_pkg::cmd_e c, input logic [TIME_W-1:0] now,
                              input logic [ID_W-1:0] tid, input logic [PER_W-1:0] per,
                              input logic [RV_W-1:0] rv, output sched_result_t res);
    logic [PER_W-1:0] delta;
    bit               ok;
    res        = '0;
    res.status = pds_pkg::ST_OK;
    case (c)
      pds_pkg::CMD_CREATE: begin
        table_put(sat_sum(now, per), tid, per, ok);
        if (!ok) res.status = pds_pkg::ST_FULL;
      end
      pds_pkg::CMD_POLL: begin
        if (run_valid) begin
          res.status = pds_pkg::ST_RUNNING;
        end else if (sched_count != 0 && now >= sched_dl[0]) begin
          run_valid = 1'b1;
          run_id    = sched_id[0];
          run_dl    = sched_dl[0];
          run_per   = sched_per[0];
          for (int k = 0; k + 1 < sched_count; k++) begin
            sched_dl[k]  = sched_dl[k+1];
            sched_id[k]  = sched_id[k+1];
            sched_per[k] = sched_per[k+1];
          end
          sched_count--;
          res.run_now  = 1'b1;
          res.due_task = run_id;
          n_pops++;
        end
      end
      pds_pkg::CMD_COMPLETE: begin
        if (!run_valid) begin
          res.status = pds_pkg::ST_NO_RUN;
        end else begin
          run_valid = 1'b0;
          // negative drops, zero reuses the period, positive is the delay
          if (!rv[RV_W-1]) begin
            delta = (rv == '0) ? run_per : rv;
            table_put(sat_sum(run_dl, delta), run_id, run_per, ok);
            if (!ok) res.status = pds_pkg::ST_FULL;
          end
        end
      end
      default: ;
    endcase
    res.queue_empty       = (sched_count == 0);
    res.earliest_deadline = (sched_count == 0) ? '0 : sched_dl[0];
  endtask

  function automatic void add_row(input pds_pkg::cmd_e c, input logic [TIME_W-1:0] now,
                                  input logic [ID_W-1:0] tid, input logic [PER_W-1:0] per,
                                  input logic [RV_W-1:0] rv, input int reps,
                                  input logic fixed, input sched_result_t res);
    stim_row_t row;
    row.cmd   = c;
    row.now   = now;
    row.tid   = tid;
    row.per   = per;
    row.rv    = rv;
    row.reps  = 5'(reps);
    row.fixed = fixed;
    row.res   = res;
    directed_rows.push_back(row);
  endfunction

  // mostly the running time base, now and then near the top or anywhere
  function automatic logic [TIME_W-1:0] pick_time();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 88) return cur_time;
    if (sel < 94) return TIME_MAX - TIME_W'($urandom_range(0, 100000));
    return TIME_W'({$urandom, $urandom});
  endfunction

  // offer one command word and hold it until accepted, then predict it;
  // a fixed result replaces the predicted one for the comparison
  task automatic send_word(input pds_pkg::cmd_e c, input logic [TIME_W-1:0] now,
                           input logic [ID_W-1:0] tid, input logic [PER_W-1:0] per,
                           input logic [RV_W-1:0] rv, input logic fixed,
                           input sched_result_t fixed_res);
    sched_result_t res;
    in_if.valid        <= 1'b1;
    in_if.cmd          <= c;
    in_if.now_time     <= now;
    in_if.task_id      <= tid;
    in_if.period       <= per;
    in_if.return_value <= rv;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    // accepted at this edge
    predict_word(c, now, tid, per, rv, res);
    expected_results.push_back(fixed ? fixed_res : res);
    n_words++;
  endtask

  task automatic check_field(input string name, input logic [TIME_W-1:0] exp_v,
                             input logic [TIME_W-1:0] act_v);
    if (act_v !== exp_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // ---------------------------------------------------------------------
  // result monitor: every accepted result word against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst_n && out_if.valid === 1'b1 && out_if.ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected, expected none, actual status %0d",
                 $time, out_if.status);
      end else begin
        exp_r = expected_results.pop_front();
        check_field("status", TIME_W'(exp_r.status), TIME_W'(out_if.status));
        check_field("run_now", TIME_W'(exp_r.run_now), TIME_W'(out_if.run_now));
        check_field("due_task", TIME_W'(exp_r.due_task), TIME_W'(out_if.due_task));
        check_field("queue_empty", TIME_W'(exp_r.queue_empty), TIME_W'(out_if.queue_empty));
        check_field("earliest_deadline", exp_r.earliest_deadline, out_if.earliest_deadline);
      end
    end
  end

  // ---------------------------------------------------------------------
  // watchdog: ends the run when no word moves on either side for too long
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid === 1'b1 && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: no word accepted for %0d cycles, %0d results outstanding",
                   $time, idle_cycles, expected_results.size());
          $display("periodic_deadline_scheduler_tb: done, errors");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // receiver: stretches of random stall patterns, plus one long hold-off
  // that lets the block fill and push back on its input
  // ---------------------------------------------------------------------
  initial begin
    int       hold_left;
    int       stretch_left;
    rx_mode_e mode;
    hold_left    = 0;
    stretch_left = 0;
    mode         = RX_OPEN;
    out_if.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (stretch_left == 0) begin
          mode         = rx_mode_e'($urandom_range(0, 3));
          stretch_left = $urandom_range(20, 200);
        end
        stretch_left--;
        case (mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_MOSTLY: out_if.ready <= ($urandom_range(0, 99) < 75);
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 99) < 30);
          default:   out_if.ready <= ~out_if.ready;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // sender: directed table, then bursts of random words
  // ---------------------------------------------------------------------
  initial begin
    int                useful;
    int                burst_left;
    int                gap;
    int unsigned       sel;
    pds_pkg::cmd_e     c;
    logic [TIME_W-1:0] now;
    logic [ID_W-1:0]   tid;
    logic [PER_W-1:0]  per;
    logic [RV_W-1:0]   rv;
    stim_row_t         row;

    clk                = 1'b0;
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.cmd          = pds_pkg::CMD_NOP;
    in_if.now_time     = '0;
    in_if.task_id      = '0;
    in_if.period       = '0;
    in_if.return_value = '0;
    errors      = 0;
    n_words     = 0;
    n_results   = 0;
    n_pops      = 0;
    n_full      = 0;
    n_sat       = 0;
    idle_cycles = 0;
    hold_req    = 1'b0;
    hold_done   = 1'b0;
    sched_count = 0;
    run_valid   = 1'b0;
    run_id      = '0;
    run_dl      = '0;
    run_per     = '0;
    cur_time    = '0;

    // empty table after reset, and the three commands that find nothing to do
    add_row(pds_pkg::CMD_POLL, '0, 8'h00, 32'd0, 32'd0, 1, 1'b1,
            '{pds_pkg::ST_OK, 1'b0, 8'h00, 1'b1, 63'd0});
    add_row(pds_pkg::CMD_COMPLETE, '0, 8'h00, 32'd0, 32'd0, 1, 1'b1,
            '{pds_pkg::ST_NO_RUN, 1'b0, 8'h00, 1'b1, 63'd0});
    add_row(pds_pkg::CMD_NOP, TIME_MAX, 8'hff, 32'hffff_ffff, 32'hffff_ffff, 1, 1'b1,
            '{pds_pkg::ST_OK, 1'b0, 8'h00, 1'b1, 63'd0});
    // largest time plus largest period clips at the top
    add_row(pds_pkg::CMD_CREATE, TIME_MAX, 8'hff, 32'hffff_ffff, 32'd0, 1, 1'b1,
            '{pds_pkg::ST_OK, 1'b0, 8'h00, 1'b0, TIME_MAX});
    add_row(pds_pkg::CMD_CREATE, '0, 8'h01, 32'd0, 32'd0, 1, 1'b1,
            '{pds_pkg::ST_OK, 1'b0, 8'h00, 1'b0, 63'd0});
    // equal deadline: the newer task goes first
    add_row(pds_pkg::CMD_CREATE, '0, 8'h02, 32'd0, 32'd0, 1, 1'b0, '0);
    add_row(pds_pkg::CMD_POLL, '0, 8'h00, 32'd0, 32'd0, 1, 1'b1,
            '{pds_pkg::ST_OK, 1'b1, 8'h02, 1'b0, 63'd0});
    // poll while a task is out
    add_row(pds_pkg::CMD_POLL, '0, 8'h00, 32'd0, 32'd0, 1, 1'b1,
            '{pds_pkg::ST_RUNNING, 1'b0, 8'h00, 1'b0, 63'd0});
    add_row(pds_pkg::CMD_COMPLETE, '0, 8'h00, 32'd0, 32'd0, 1, 1'b0, '0);
    add_row(pds_pkg::CMD_POLL, '0, 8'h00, 32'd0, 32'd0, 1, 1'b0, '0);
    add_row(pds_pkg::CMD_COMPLETE, '0, 8'h00, 32'd0, 32'hffff_ffff, 1, 1'b0, '0);
    add_row(pds_pkg::CMD_POLL, '0, 8'h00, 32'd0, 32'd0, 1, 1'b0, '0);
    add_row(pds_pkg::CMD_COMPLETE, '0, 8'h00, 32'd0, 32'h7fff_ffff, 1, 1'b0, '0);
    // head not yet due
    add_row(pds_pkg::CMD_POLL, 63'd5, 8'h00, 32'd0, 32'd0, 1, 1'b0, '0);
    add_row(pds_pkg::CMD_POLL, TIME_MAX, 8'h00, 32'd0, 32'd0, 1, 1'b0, '0);
    // fill the table while a task is out, then overflow it both ways
    add_row(pds_pkg::CMD_CREATE, 63'd100, 8'h55, 32'h0000_aaaa, 32'd0, 15, 1'b0, '0);
    add_row(pds_pkg::CMD_CREATE, '0, 8'haa, 32'd1, 32'd0, 1, 1'b1,
            '{pds_pkg::ST_FULL, 1'b0, 8'h00, 1'b0, 63'd43790});
    add_row(pds_pkg::CMD_COMPLETE, '0, 8'h00, 32'd0, 32'd5, 1, 1'b1,
            '{pds_pkg::ST_FULL, 1'b0, 8'h00, 1'b0, 63'd43790});
    add_row(pds_pkg::CMD_POLL, TIME_MAX, 8'h00, 32'd0, 32'd0, 1, 1'b0, '0);
    // most negative return value drops the task
    add_row(pds_pkg::CMD_COMPLETE, '0, 8'h00, 32'd0, 32'h8000_0000, 1, 1'b0, '0);
    add_row(pds_pkg::CMD_CREATE, TIME_MAX, 8'h33, 32'd1, 32'd0, 1, 1'b0, '0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, back to back
    foreach (directed_rows[r]) begin
      row = directed_rows[r];
      for (int i = 0; i < row.reps; i++) begin
        send_word(row.cmd, row.now + TIME_W'(i), row.tid + ID_W'(i), row.per, row.rv,
                  row.fixed, row.res);
      end
    end

    // random part: mostly commands that make sense for the predicted state,
    // with some noise words on every field
    useful     = 0;
    burst_left = $urandom_range(1, 20);
    while (useful < N_RANDOM) begin
      cur_time = cur_time + TIME_W'($urandom_range(0, 12));
      tid      = ID_W'($urandom);
      per      = $urandom;
      rv       = $urandom;
      now      = TIME_W'({$urandom, $urandom});
      sel      = $urandom_range(0, 99);
      if (sel < 6) begin
        c = pds_pkg::cmd_e'($urandom_range(0, 3));
      end else begin
        sel = $urandom_range(0, 99);
        if (run_valid) begin
          c = (sel < 55) ? pds_pkg::CMD_COMPLETE :
              (sel < 70) ? pds_pkg::CMD_POLL : pds_pkg::CMD_CREATE;
        end else if (sched_count == 0) begin
          c = (sel < 95) ? pds_pkg::CMD_CREATE : pds_pkg::CMD_COMPLETE;
        end else if (sched_count >= MAX_TASKS) begin
          c = (sel < 70) ? pds_pkg::CMD_POLL : pds_pkg::CMD_CREATE;
        end else begin
          c = (sel < 45) ? pds_pkg::CMD_CREATE :
              (sel < 95) ? pds_pkg::CMD_POLL : pds_pkg::CMD_COMPLETE;
        end
        case (c)
          pds_pkg::CMD_CREATE: begin
            sel = $urandom_range(0, 99);
            if (sel < 85) per = $urandom_range(0, 100);
            else if (sel < 90) per = '0;
            now = pick_time();
          end
          pds_pkg::CMD_POLL: begin
            now = pick_time();
          end
          pds_pkg::CMD_COMPLETE: begin
            sel = $urandom_range(0, 99);
            if (sel < 40) rv = '0;
            else if (sel < 70) rv = $urandom_range(1, 100);
            else if (sel < 90) rv = rv | 32'h8000_0000;
          end
          default: ;
        endcase
      end

      send_word(c, now, tid, per, rv, 1'b0, '0);
      if (c != pds_pkg::CMD_NOP) useful++;

      // the receiver starts its long hold while words keep coming
      if (useful == HOLD_AT) hold_req = 1'b1;

      if (c != pds_pkg::CMD_NOP && useful == PAUSE_AT) begin
        // stop offering until every result word is back
        in_if.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
      end else begin
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 20);
          gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          if (gap != 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
    end

    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d command words and %0d result words", n_words, n_results);
    $display("with %0d pops, %0d full rejects and %0d clipped deadline sums",
             n_pops, n_full, n_sat);
    if (errors == 0) begin
      $display("periodic_deadline_scheduler_tb: done, clean");
    end else begin
      $display("periodic_deadline_scheduler_tb: done, errors");
    end
    $finish;
  end

endmodule
